// ----- rtl/isa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package isa_pkg;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd1;

    localparam logic [31:0] RESET_MIN_IDLE = 32'd10000;
    localparam logic [5:0]  RESET_START    = 6'd0;

    // one queued command; word carries the stamp of an update or the time of a find
    typedef struct packed {
        logic        kind;
        logic [5:0]  slot;
        logic        busy;
        logic        held;
        logic [31:0] word;
    } t_cmd;

    typedef struct packed {
        logic [31:0] min_idle;
        logic [5:0]  start;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/isa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isa_front
    import isa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_kind,
    input  wire logic [5:0]           i_slot,
    input  wire logic                 i_in_use,
    input  wire logic                 i_allocated,
    input  wire logic [31:0]          i_stamp,
    input  wire logic [31:0]          i_now_ticks,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire logic                 i_full,
    output logic                      o_push,
    output t_cmd                      o_cmd,
    output t_cfg                      o_cfg
);

    logic [31:0] r_min_idle;
    logic [5:0]  r_start;
    logic        slot_ok;
    logic        start_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_idle <= RESET_MIN_IDLE;
            r_start    <= RESET_START;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_IDLE: r_min_idle <= i_cfg_data;
                CFG_START:    r_start    <= i_cfg_data[5:0];
                default:      ;
            endcase
        end
    end

    // hold off register writes while in reset
    assign o_cfg_ready = i_rst_n;

    // drop updates that name a slot past the table
    assign slot_ok  = {7'd0, i_slot} < 13'(SLOTS);
    assign start_ok = {7'd0, r_start} < 13'(SLOTS);

    // hold off commands while in reset or while the queue is full
    assign busy   = i_full || !i_rst_n;
    assign o_push = start && !busy && (i_kind == KIND_FIND || slot_ok);

    always_comb begin
        o_cmd.kind = i_kind;
        o_cmd.slot = i_slot;
        o_cmd.busy = i_in_use;
        o_cmd.held = i_allocated;
        o_cmd.word = (i_kind == KIND_FIND) ? i_now_ticks : i_stamp;
    end

    assign o_cfg.min_idle = r_min_idle;
    assign o_cfg.start    = start_ok ? r_start : 6'd0;

endmodule

`default_nettype wire

// ----- rtl/isa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isa_queue
    import isa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output logic      o_empty,
    output logic      o_full
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: ;
            endcase
        end
    end

    assign o_cmd   = r_entry[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

endmodule

`default_nettype wire

// ----- rtl/isa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module isa_back
    import isa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_cmd       i_cmd,
    output logic            o_pop,
    input  wire t_cfg       i_cfg,
    output logic            o_done,
    output logic            o_found,
    output logic [5:0]      o_chosen_slot,
    output logic            o_by_idle
);

    // only slots 0..63 can be written; slots past that read as free and unheld
    localparam int NFLAG = (SLOTS < 64) ? SLOTS : 64;
    localparam int NW    = $clog2(NFLAG);
    localparam int SW    = $clog2(SLOTS);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} t_state;

    t_state          r_state;
    logic [NFLAG-1:0] r_busy_flags;
    logic [NFLAG-1:0] r_held_flags;
    logic [31:0]     r_stamps [NFLAG];
    logic [31:0]     r_rdata;
    logic [SW-1:0]   r_idx;
    logic [31:0]     r_now;
    logic            r_p_valid;
    logic            r_p_busy;
    logic            r_p_held;
    logic [5:0]      r_p_slot;
    logic            r_p_ge;
    logic            r_have;
    logic [31:0]     r_best_idle;
    logic [5:0]      r_best_slot;
    logic            r_ge_have;
    logic [5:0]      r_ge_slot;
    logic            r_any_have;
    logic [5:0]      r_any_slot;
    logic            r_done;
    logic            r_found;
    logic [5:0]      r_chosen;
    logic            r_by_idle;

    logic            do_update;
    logic [NW-1:0]   wr_addr;
    logic [NW-1:0]   rd_addr;
    logic            idx_in_table;
    logic [SW-1:0]   start_idx;
    logic [31:0]     idle;
    logic            cand;
    logic            free;

    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign do_update = o_pop && (i_cmd.kind == KIND_UPDATE);
    assign wr_addr   = NW'(i_cmd.slot);
    assign rd_addr   = NW'(r_idx);
    assign start_idx = SW'({{SW{1'b0}}, i_cfg.start});

    assign idx_in_table = {1'b0, r_idx} < (SW+1)'(NFLAG);

    // stage two: score the slot whose stamp was read last cycle
    assign idle = r_now - r_rdata;
    assign cand = r_p_valid && !r_p_busy && r_p_held
                  && (idle > i_cfg.min_idle) && (idle > r_best_idle);
    assign free = r_p_valid && !r_p_busy;

    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_stamps[wr_addr] <= i_cmd.word;
        end
        r_rdata <= r_stamps[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_busy_flags <= '0;
            r_held_flags <= '0;
            r_p_valid    <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done    <= 1'b0;
            r_p_valid <= 1'b0;

            if (cand) begin
                r_have      <= 1'b1;
                r_best_idle <= idle;
                r_best_slot <= r_p_slot;
            end
            if (free && !r_any_have) begin
                r_any_have <= 1'b1;
                r_any_slot <= r_p_slot;
            end
            if (free && r_p_ge && !r_ge_have) begin
                r_ge_have <= 1'b1;
                r_ge_slot <= r_p_slot;
            end

            case (r_state)
                ST_IDLE: begin
                    if (do_update) begin
                        r_busy_flags[wr_addr] <= i_cmd.busy;
                        r_held_flags[wr_addr] <= i_cmd.held;
                    end else if (o_pop) begin
                        r_now       <= i_cmd.word;
                        r_idx       <= '0;
                        r_have      <= 1'b0;
                        r_best_idle <= '0;
                        r_ge_have   <= 1'b0;
                        r_any_have  <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // stage one: fetch flags now, stamp arrives next cycle
                    r_p_valid <= 1'b1;
                    r_p_busy  <= idx_in_table && r_busy_flags[rd_addr];
                    r_p_held  <= idx_in_table && r_held_flags[rd_addr];
                    r_p_slot  <= 6'({{6{1'b0}}, r_idx});
                    r_p_ge    <= r_idx >= start_idx;
                    r_idx     <= r_idx + 1'b1;
                    if (r_idx == SW'(SLOTS - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    r_done    <= 1'b1;
                    r_found   <= r_have || r_ge_have || r_any_have;
                    r_by_idle <= r_have;
                    if (r_have) begin
                        r_chosen <= r_best_slot;
                    end else if (r_ge_have) begin
                        r_chosen <= r_ge_slot;
                    end else if (r_any_have) begin
                        r_chosen <= r_any_slot;
                    end else begin
                        r_chosen <= 6'd0;
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_chosen_slot = r_chosen;
    assign o_by_idle     = r_by_idle;

endmodule

`default_nettype wire

// ----- rtl/idle_slot_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                  | word
// ----------+----------------------------+------------------------------------------
// command   | start / busy               | i_kind i_slot i_in_use i_allocated
//           |                            | i_stamp i_now_ticks
// result    | o_done (one-cycle strobe)  | o_found o_chosen_slot o_by_idle
// config    | i_cfg_valid / o_cfg_ready  | i_cfg_index i_cfg_data
//
// An update is done in the executor's idle state; a find steps through the scan,
// drain and done states, its scan reading one stamp per cycle from the table.
// A two-word queue sits between the command port and the executor, so busy
// rises when two words wait behind the one in progress, and also in reset.
// Reset (synchronous, active low) clears all flags, the queue and the
// registers to their defaults; stamps are left as they are.
// Results cannot be stalled: each one shows for exactly one cycle.

module idle_slot_allocator
    import isa_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 i_kind,
    input  wire logic [5:0]           i_slot,
    input  wire logic                 i_in_use,
    input  wire logic                 i_allocated,
    input  wire logic [31:0]          i_stamp,
    input  wire logic [31:0]          i_now_ticks,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_done,
    output logic                      o_found,
    output logic [5:0]                o_chosen_slot,
    output logic                      o_by_idle
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd cmd_in;
    t_cmd cmd_out;
    t_cfg cfg;

    // front: hold config, drop out-of-range updates, pack the word
    isa_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_slot      (i_slot),
        .i_in_use    (i_in_use),
        .i_allocated (i_allocated),
        .i_stamp     (i_stamp),
        .i_now_ticks (i_now_ticks),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .o_cfg       (cfg)
    );

    // queue: keep command order between front and executor
    isa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty),
        .o_full  (full)
    );

    // executor: write slots, scan the table for a find
    isa_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_cmd         (cmd_out),
        .o_pop         (pop),
        .i_cfg         (cfg),
        .o_done        (o_done),
        .o_found       (o_found),
        .o_chosen_slot (o_chosen_slot),
        .o_by_idle     (o_by_idle)
    );

endmodule

`default_nettype wire
